// ===== design/carb_pkg.sv =====
package carb_pkg;

    // input actions
    localparam logic [1:0] ACT_OPEN  = 2'd0;
    localparam logic [1:0] ACT_DATA  = 2'd1;
    localparam logic [1:0] ACT_DRAIN = 2'd2;
    localparam logic [1:0] ACT_SEND  = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_ADMIT = 2'd0;
    localparam logic [1:0] KIND_BYTE  = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    // send outcomes; anything else counts as an error
    localparam logic [1:0] SEND_OK   = 2'd0;
    localparam logic [1:0] SEND_BUSY = 2'd1;

    // register select, taken from paddr[2]
    localparam logic CFG_LINK  = 1'b0;
    localparam logic CFG_LIMIT = 1'b1;

    localparam int LEN_W   = 15;
    localparam int LIMIT_W = 7;

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } carb_state_t;

    // status of the registered read stage of the ring
    typedef struct packed {
        logic valid;
        logic last;
    } carb_rd_stat_t;

endpackage

// ===== design/carb_ring.sv =====
module carb_ring
    import carb_pkg::*;
#(
    parameter int DEPTH = 16384,
    parameter int AW    = 14
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    input  logic          rd_last,
    input  logic          rd_take,
    output carb_rd_stat_t rd_stat,
    output logic [7:0]    rd_data
);

    logic [7:0]    mem [DEPTH];
    logic [7:0]    rd_data_reg;
    carb_rd_stat_t rd_stat_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // hold the read byte until the output stage takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_stat_reg <= '0;
        end else if (rd_en) begin
            rd_stat_reg.valid <= 1'b1;
            rd_stat_reg.last  <= rd_last;
        end else if (rd_take) begin
            rd_stat_reg.valid <= 1'b0;
        end
    end

    assign rd_stat = rd_stat_reg;
    assign rd_data = rd_data_reg;

endmodule

// ===== design/chunk_admission_ring_buffer.sv =====
// Channel   Ports                                   Direction
// input     s_valid/s_ready, s_action .. s_send_outcome   in
// result    m_valid/m_ready, m_kind .. m_sent_total       out
// config    psel/penable/pwrite/paddr/pwdata/prdata/pready  APB
//
// An open with the link enabled and a nonzero length, or an empty drain,
// leaves one result in the output register. A drain of n bytes, the lesser
// of committed bytes and frame limit, issues one ring read per cycle into a
// registered read stage while that stage is free or being emptied, and each
// byte then moves from that stage into the output register.
// Reset (aresetn low, synchronous) clears pointers, counts, link enable and
// valid flags; the ring is not cleared, only committed bytes are ever read.
// A stalled result holds the output and read stages; input is taken only when
// the output register is free or being emptied, and never during a drain.
module chunk_admission_ring_buffer
    import carb_pkg::*;
#(
    parameter int RING_BYTES = 16384,
    parameter int MAX_FRAME  = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_action,
    input  logic [LEN_W-1:0]     s_chunk_length,
    input  logic [7:0]           s_data_byte,
    input  logic [1:0]           s_send_outcome,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_kind,
    output logic                 m_admitted,
    output logic [7:0]           m_frame_byte,
    output logic                 m_frame_last,
    output logic [31:0]          m_frame_sequence,
    output logic [31:0]          m_dropped_total,
    output logic [31:0]          m_sent_total,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int AW    = $clog2(RING_BYTES);
    localparam int UW    = $clog2(RING_BYTES + 1);
    localparam int FW    = $clog2(MAX_FRAME + 1);
    localparam int CMP_W = (UW > LEN_W) ? UW : LEN_W;
    localparam int NW    = (UW > FW) ? UW : FW;

    carb_state_t        state_reg, state_next;
    logic               link_en_reg;
    logic [LIMIT_W-1:0] frame_limit_reg;
    logic [AW-1:0]      commit_head_reg;
    logic [AW-1:0]      write_cursor_reg;
    logic [AW-1:0]      read_tail_reg;
    logic [UW-1:0]      used_reg;
    logic [LEN_W-1:0]   remain_reg;
    logic [LEN_W-1:0]   pending_reg;
    logic               chunk_open_reg;
    logic [31:0]        seq_reg;
    logic [31:0]        sent_reg;
    logic [31:0]        drop_reg;
    logic [FW-1:0]      issue_left_reg;
    logic               m_valid_reg;
    logic [1:0]         m_kind_reg;
    logic               m_admitted_reg;
    logic [7:0]         m_frame_byte_reg;
    logic               m_frame_last_reg;

    logic               in_fire;
    logic               out_free;
    logic               cfg_write;
    logic               open_go;
    logic               fits;
    logic               data_go;
    logic [AW-1:0]      cursor_inc;
    logic [AW-1:0]      tail_inc;
    logic [FW-1:0]      lim_c;
    logic [FW-1:0]      n_c;
    logic               rd_en;
    logic               load_byte;
    carb_rd_stat_t      rd_stat;
    logic [7:0]         rd_data;

    assign out_free  = !m_valid_reg || m_ready;
    assign in_fire   = s_valid && s_ready;
    assign cfg_write = psel && penable && pwrite && pready;

    assign open_go = in_fire && (s_action == ACT_OPEN) && link_en_reg
                     && (s_chunk_length != '0);
    assign fits    = CMP_W'(s_chunk_length)
                     <= (CMP_W'(RING_BYTES) - CMP_W'(used_reg));
    assign data_go = in_fire && (s_action == ACT_DATA) && chunk_open_reg;

    assign cursor_inc = (write_cursor_reg == AW'(RING_BYTES - 1)) ? '0
                        : write_cursor_reg + AW'(1);
    assign tail_inc   = (read_tail_reg == AW'(RING_BYTES - 1)) ? '0
                        : read_tail_reg + AW'(1);

    // clamp the frame limit into 1..MAX_FRAME
    always_comb begin
        if (frame_limit_reg == '0) begin
            lim_c = FW'(1);
        end else if (frame_limit_reg > LIMIT_W'(MAX_FRAME)) begin
            lim_c = FW'(MAX_FRAME);
        end else begin
            lim_c = FW'(frame_limit_reg);
        end
    end

    assign n_c = (NW'(used_reg) < NW'(lim_c)) ? FW'(used_reg) : lim_c;

    assign load_byte = rd_stat.valid && out_free;
    assign rd_en     = (state_reg == ST_DRAIN) && (issue_left_reg != '0)
                       && (!rd_stat.valid || load_byte);

    carb_ring #(
        .DEPTH (RING_BYTES),
        .AW    (AW)
    ) u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (data_go),
        .wr_addr (write_cursor_reg),
        .wr_data (s_data_byte),
        .rd_en   (rd_en),
        .rd_addr (read_tail_reg),
        .rd_last (issue_left_reg == FW'(1)),
        .rd_take (load_byte),
        .rd_stat (rd_stat),
        .rd_data (rd_data)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire && (s_action == ACT_DRAIN) && (n_c != '0)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if ((issue_left_reg == '0) && (!rd_stat.valid || load_byte)) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        case (state_reg)
            ST_IDLE:  s_ready = out_free;
            ST_DRAIN: s_ready = 1'b0;
            default:  s_ready = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_en_reg     <= 1'b0;
            frame_limit_reg <= LIMIT_W'(64);
        end else if (cfg_write) begin
            if (paddr[2] == CFG_LINK) begin
                link_en_reg <= pwdata[0];
            end else begin
                frame_limit_reg <= pwdata[LIMIT_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == CFG_LIMIT) begin
            prdata = {{(32 - LIMIT_W){1'b0}}, frame_limit_reg};
        end else begin
            prdata = {31'd0, link_en_reg};
        end
    end

    assign pready = 1'b1;

    // ring pointers, occupancy and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            commit_head_reg  <= '0;
            write_cursor_reg <= '0;
            read_tail_reg    <= '0;
            used_reg         <= '0;
            remain_reg       <= '0;
            pending_reg      <= '0;
            chunk_open_reg   <= 1'b0;
            seq_reg          <= '0;
            sent_reg         <= '0;
            drop_reg         <= '0;
            issue_left_reg   <= '0;
        end else begin
            if (open_go) begin
                // a new open abandons any chunk in progress
                write_cursor_reg <= commit_head_reg;
                chunk_open_reg   <= fits;
                remain_reg       <= fits ? s_chunk_length : '0;
                pending_reg      <= fits ? s_chunk_length : '0;
                if (!fits) begin
                    drop_reg <= drop_reg + 32'd1;
                end
            end
            if (data_go) begin
                write_cursor_reg <= cursor_inc;
                remain_reg       <= remain_reg - LEN_W'(1);
                if (remain_reg == LEN_W'(1)) begin
                    commit_head_reg <= cursor_inc;
                    used_reg        <= UW'(CMP_W'(used_reg) + CMP_W'(pending_reg));
                    pending_reg     <= '0;
                    chunk_open_reg  <= 1'b0;
                end
            end
            if (in_fire && (s_action == ACT_DRAIN)) begin
                used_reg       <= used_reg - UW'(n_c);
                issue_left_reg <= n_c;
            end
            if (in_fire && (s_action == ACT_SEND)) begin
                if (s_send_outcome == SEND_OK) begin
                    seq_reg  <= seq_reg + 32'd1;
                    sent_reg <= sent_reg + 32'd1;
                end else if (s_send_outcome != SEND_BUSY) begin
                    drop_reg <= drop_reg + 32'd1;
                end
            end
            if (rd_en) begin
                read_tail_reg  <= tail_inc;
                issue_left_reg <= issue_left_reg - FW'(1);
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (open_go || (in_fire && (s_action == ACT_DRAIN) && (n_c == '0))
                || load_byte) begin
                m_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (open_go) begin
            m_kind_reg       <= KIND_ADMIT;
            m_admitted_reg   <= fits;
            m_frame_byte_reg <= '0;
            m_frame_last_reg <= 1'b0;
        end else if (in_fire && (s_action == ACT_DRAIN) && (n_c == '0)) begin
            m_kind_reg       <= KIND_EMPTY;
            m_admitted_reg   <= 1'b0;
            m_frame_byte_reg <= '0;
            m_frame_last_reg <= 1'b0;
        end else if (load_byte) begin
            m_kind_reg       <= KIND_BYTE;
            m_admitted_reg   <= 1'b0;
            m_frame_byte_reg <= rd_data;
            m_frame_last_reg <= rd_stat.last;
        end
    end

    // counters only move on accepted input, which waits for a free output
    assign m_valid          = m_valid_reg;
    assign m_kind           = m_kind_reg;
    assign m_admitted       = m_admitted_reg;
    assign m_frame_byte     = m_frame_byte_reg;
    assign m_frame_last     = m_frame_last_reg;
    assign m_frame_sequence = seq_reg;
    assign m_dropped_total  = drop_reg;
    assign m_sent_total     = sent_reg;

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        UW'(used_reg) <= UW'(RING_BYTES))
        else $error("committed bytes exceed ring size");

    a_no_input_in_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN) |-> !s_ready)
        else $error("input taken during drain");

    a_read_stage_in_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_stat.valid |-> (state_reg == ST_DRAIN))
        else $error("read stage busy outside drain");

    a_last_ends_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_byte && rd_stat.last) |-> (issue_left_reg == '0))
        else $error("frame end marked with reads outstanding");

    a_open_has_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        chunk_open_reg |-> (remain_reg != '0))
        else $error("open chunk with no bytes left");
`endif

endmodule
